>>> rtl/core/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared codes and field widths for the nixie tube crossfade dimmer.
// ----------------------------------------------------------------------------
package tcd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_GLOBAL_LEVEL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TUBE_LEVELS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DOT_LEVEL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_ENABLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BLANK_ALL    = 3'd4;

   localparam logic OP_FRAME     = 1'b0;
   localparam logic OP_SET_DIGIT = 1'b1;

   localparam logic [3:0] BLANK_CODE     = 4'hf;
   localparam int         FADE_STEP_BITS = 5;

   typedef logic [3:0] level_type;

endpackage

>>> rtl/core/tube_crossfade_dimmer_top.sv
// ----------------------------------------------------------------------------
// tube_crossfade_dimmer_top
// Nixie tube multiplex engine with per-tube dimming, crossfade and dot sharing.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word: a set-digit word (opcode 1) stores a digit code
//   for one tube and gives no response; a frame word (opcode 0) advances the
//   frame phase and gives one rsp_* word with the three shift-register bytes
//   and the decimal point pins.
//   csr_* writes the configuration registers; csr_ready is always high.
//   Write them only while no frame is in flight.
// Timing:
//   A frame word walks the tubes one per cycle through a shared 4x4 level
//   multiplier followed by a fade scaler, then uses the multiplier once more
//   for the dot level before the response is loaded; a frame skips the walk
//   when blank_all is set. req_ready is low while a frame is being worked.
// Reset:
//   Clears digits, fade timers, frame phase and loads the register defaults.
// Stall:
//   The response register holds a finished word; set-digit words and one more
//   frame are still taken, and that frame then waits until the word is taken.
// ----------------------------------------------------------------------------
module tube_crossfade_dimmer_top #(
   parameter int TUBES      = 6,
   parameter int FADE_TICKS = 1023
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [2:0]  req_tube_index,
   input  logic [3:0]  req_digit_value,
   input  logic [6:0]  req_dot_mask,
   input  logic [1:0]  req_edit_pair,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_tube_codes,
   output logic [5:0]  rsp_dot_drive,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IW   = (TUBES > 1) ? $clog2(TUBES) : 1;
   localparam int CNTW = $clog2(TUBES + 1);
   localparam int TW   = $clog2(FADE_TICKS + 1);
   localparam int HALF = FADE_TICKS / 2;
   localparam int FW   = TW - tcd_pkg::FADE_STEP_BITS;
   localparam int PW   = 4 + FW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // configuration
   tcd_pkg::level_type global_level_ff;
   logic [23:0]        tube_levels_ff;
   tcd_pkg::level_type dot_level_ff;
   logic [5:0]         fade_enable_ff;
   logic               blank_all_ff;

   // tube state
   logic [3:0]    shown_ff    [TUBES];
   logic [3:0]    previous_ff [TUBES];
   logic [TW-1:0] timer_ff    [TUBES];
   logic [3:0]    phase_ff;

   // sequencer
   logic [1:0]      state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0]   cnt_i;

   // frame context
   logic [6:0] dp_ff;
   logic [1:0] edit_ff;
   logic       disp_ff;

   // stage A to stage B
   logic               s_valid_ff;
   logic [IW-1:0]      s_idx_ff;
   tcd_pkg::level_type s_lvl_ff;
   logic [FW-1:0]      s_fade_ff;
   logic               s_use_fade_ff;
   logic               s_edit_show_ff;
   logic [3:0]         s_digit_ff;

   logic [TUBES-1:0][3:0] codes_ff;
   logic [5:0]            dots_ff;

   logic        rsp_valid_ff, out_valid_in, load_out;
   logic [23:0] rsp_codes_ff;
   logic [5:0]  rsp_dots_ff;

   logic req_fire, frame_fire, set_fire, a_act, dot_step;
   logic [3:0] phase_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_valid && req_ready;
   assign frame_fire = req_fire && (req_opcode == tcd_pkg::OP_FRAME);
   assign set_fire   = req_fire && (req_opcode == tcd_pkg::OP_SET_DIGIT);
   assign phase_in   = phase_ff + 4'd1;
   assign cnt_i      = cnt_ff[IW-1:0];
   assign a_act      = (state_ff == ST_RUN) && (cnt_ff != CNTW'(TUBES));
   assign dot_step   = (state_ff == ST_RUN) && (cnt_ff == CNTW'(TUBES));

   // shared level multiplier: one tube per step, then the dot level
   logic [5:0]         lvl_shift;
   tcd_pkg::level_type tube_lvl, mul_b;
   logic [7:0]         mul_p;
   tcd_pkg::level_type mul_hi;

   assign lvl_shift = 6'(4 * (TUBES - 1)) - 6'({cnt_i, 2'b00});
   assign tube_lvl  = 4'(tube_levels_ff >> lvl_shift);
   assign mul_b     = a_act ? tube_lvl : dot_level_ff;
   assign mul_p     = global_level_ff * mul_b;
   assign mul_hi    = mul_p[7:4];

   // stage A decode for the current tube
   logic [7:0]    fe8;
   logic          fade_en, use_fade, older;
   logic [TW-1:0] t_cur;
   logic [TW-1:0] fade_full;
   logic          edit_show;

   assign fe8       = 8'(fade_enable_ff);
   assign fade_en   = fe8[3'(TUBES - 1) - 3'(cnt_i)];
   assign t_cur     = timer_ff[cnt_i];
   assign use_fade  = fade_en && (t_cur != '0);
   assign older     = t_cur > TW'(HALF);
   assign fade_full = older ? (t_cur - TW'(HALF)) : (TW'(HALF) - t_cur);
   assign edit_show = (3'(cnt_i >> 1) == 3'(edit_ff - 2'd1)) || (phase_ff < 4'd4);

   // stage B: fade scale and PWM compare
   logic [PW-1:0] fade_p;
   logic [PW-1:0] lvl_b;
   logic          show_b;
   logic [3:0]    code_b;

   assign fade_p = PW'(s_lvl_ff) * PW'(s_fade_ff);
   assign lvl_b  = s_use_fade_ff ? PW'(fade_p[PW-1:4]) : PW'(s_lvl_ff);

   always_comb begin
      show_b = 1'b0;
      if (disp_ff) begin
         if (edit_ff != 2'd0) begin
            show_b = s_edit_show_ff;
         end else begin
            show_b = PW'(phase_ff) <= lvl_b;
         end
      end
      code_b = show_b ? s_digit_ff : tcd_pkg::BLANK_CODE;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = rsp_valid_ff && !rsp_ready;
      load_out     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (frame_fire) begin
               state_in = blank_all_ff ? ST_DONE : ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (cnt_ff == CNTW'(TUBES)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s_valid_ff   <= a_act;
         rsp_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_level_ff <= 4'd15;
         tube_levels_ff  <= 24'hffffff;
         dot_level_ff    <= 4'd15;
         fade_enable_ff  <= 6'd0;
         blank_all_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tcd_pkg::REG_GLOBAL_LEVEL: global_level_ff <= csr_wdata[3:0];
            tcd_pkg::REG_TUBE_LEVELS:  tube_levels_ff  <= csr_wdata[23:0];
            tcd_pkg::REG_DOT_LEVEL:    dot_level_ff    <= csr_wdata[3:0];
            tcd_pkg::REG_FADE_ENABLE:  fade_enable_ff  <= csr_wdata[5:0];
            tcd_pkg::REG_BLANK_ALL:    blank_all_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // tube state: store digits, count fades down
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TUBES; i++) begin
            shown_ff[i]    <= 4'd0;
            previous_ff[i] <= 4'd0;
            timer_ff[i]    <= '0;
         end
         phase_ff <= 4'd0;
      end else begin
         if (frame_fire) begin
            phase_ff <= phase_in;
         end
         if (set_fire && (4'(req_tube_index) < 4'(TUBES))) begin
            if (req_digit_value != shown_ff[req_tube_index[IW-1:0]]) begin
               previous_ff[req_tube_index[IW-1:0]] <= shown_ff[req_tube_index[IW-1:0]];
               shown_ff[req_tube_index[IW-1:0]]    <= req_digit_value;
               timer_ff[req_tube_index[IW-1:0]]    <= TW'(FADE_TICKS);
            end
         end
         if (a_act && disp_ff && (edit_ff == 2'd0) && (t_cur != '0)) begin
            timer_ff[cnt_i] <= t_cur - TW'(1);
         end
      end
   end

   // frame datapath
   always_ff @(posedge clock) begin
      if (frame_fire) begin
         dp_ff    <= req_dot_mask;
         edit_ff  <= req_edit_pair;
         disp_ff  <= (req_dot_mask == 7'd0) || (phase_in[1:0] != 2'd0);
         codes_ff <= {TUBES{tcd_pkg::BLANK_CODE}};
         dots_ff  <= 6'd0;
      end
      if (a_act) begin
         s_idx_ff       <= cnt_i;
         s_lvl_ff       <= mul_hi;
         s_fade_ff      <= FW'(fade_full >> tcd_pkg::FADE_STEP_BITS);
         s_use_fade_ff  <= use_fade;
         s_edit_show_ff <= edit_show;
         s_digit_ff     <= (edit_ff == 2'd0 && use_fade && older) ?
                           previous_ff[cnt_i] : shown_ff[cnt_i];
      end
      if (s_valid_ff) begin
         codes_ff[s_idx_ff] <= code_b;
      end
      if (dot_step) begin
         dots_ff <= (!disp_ff && (phase_ff <= mul_hi)) ? dp_ff[5:0] : 6'd0;
      end
      if (load_out) begin
         rsp_codes_ff <= 24'(32'(codes_ff));
         rsp_dots_ff  <= dots_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tube_codes = rsp_codes_ff;
   assign rsp_dot_drive  = rsp_dots_ff;

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff <= CNTW'(TUBES)))
      else $error("tube counter past last step");

   a_stage_in_run: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> (state_ff == ST_RUN))
      else $error("stage B active outside a frame walk");

   a_blank_skip: assert property (@(posedge clock) disable iff (reset)
      (frame_fire && blank_all_ff) |=> (state_ff == ST_DONE))
      else $error("blanked frame did not go straight to output");

   a_load_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished frame not loaded into output register");
`endif

endmodule
